/* rtl/tsrp_pkg.sv */
// ---------------------------------------------------------------------------
// tsrp_pkg: shared types and constants of the step rate planner
// Register indexes, pipeline depths and the stage records handed along the
// square root and divider cell chains.
// ---------------------------------------------------------------------------
package tsrp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MARG  = 3'd6;

  localparam logic [15:0] MAX_VEL_RST   = 16'd1000;
  localparam logic [23:0] ACCEL_RST     = 24'd2000;
  localparam logic [15:0] MIN_RATE_RST  = 16'd400;
  localparam logic [9:0]  TICK_MS_RST   = 10'd10;
  localparam logic [9:0]  TICK_MARG_RST = 10'd20;

  localparam logic [23:0] RATE_SAT   = 24'hFFFFFF;
  localparam logic [9:0]  TICK_SCALE = 10'd1000;
  localparam logic [10:0] TRI_SCALE  = 11'd2000;

  // Square root: 48-bit radicand, two bits per cell.
  localparam int SQ_STEPS  = 24;
  // Divider: 33 quotient bits, one per cell.
  localparam int DIV_STEPS = 33;
  localparam int FRONT_STAGES = 3;
  localparam int NST = FRONT_STAGES + SQ_STEPS + 1 + DIV_STEPS + 1;

  typedef struct packed {
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } sq_lane_t;

  typedef struct packed {
    logic        zero;
    logic        remnz;
    logic        is_tri;
    logic        acc_sat;
    logic        dec_sat;
    logic [66:0] tnum;
    logic [49:0] avt;
    logic [41:0] tden;
  } side_t;

  typedef struct packed {
    sq_lane_t acc;
    sq_lane_t dec;
    sq_lane_t pk;
    side_t    side;
  } sq_stage_t;

  typedef struct packed {
    logic [32:0] n;
    logic [49:0] r;
    logic [32:0] q;
    logic [49:0] d;
    logic        ovf;
    logic        zero;
    logic        is_tri;
    logic [23:0] rate;
    logic [23:0] peak;
  } dv_stage_t;

endpackage

/* rtl/tsrp_if.sv */
// ---------------------------------------------------------------------------
// tsrp_if: position request and rate result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface tsrp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_position;

  modport source (output valid, output current_position, input ready);
  modport sink (input valid, input current_position, output ready);
endinterface

interface tsrp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] step_rate;
  logic [23:0] peak_velocity;
  logic        triangular;
  logic [31:0] tick_estimate;

  modport source (output valid, output step_rate, output peak_velocity,
                  output triangular, output tick_estimate, input ready);
  modport sink (input valid, input step_rate, input peak_velocity,
                input triangular, input tick_estimate, output ready);
endinterface

/* rtl/tsrp_front.sv */
// ---------------------------------------------------------------------------
// tsrp_front: distance and product stages
// Three stages: step distances, products with the acceleration, then the
// radicands, profile select and dividend/divisor for the tick estimate.
// ---------------------------------------------------------------------------
module tsrp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          take,
  input  logic                in_valid,
  input  logic signed [31:0]  cur,
  input  logic signed [31:0]  start_pos,
  input  logic signed [31:0]  target_pos,
  input  logic [15:0]         v_eff,
  input  logic [23:0]         a_eff,
  input  logic [9:0]          t_eff,
  output logic [2:0]          out_valid,
  output tsrp_pkg::sq_stage_t out_data
);
  import tsrp_pkg::*;

  function automatic logic [31:0] abs_diff(input logic signed [31:0] x,
                                           input logic signed [31:0] y);
    logic [32:0] df;
    df = {y[31], y} - {x[31], x};
    abs_diff = df[32] ? 32'(-df) : df[31:0];
  endfunction

  logic [31:0] trav, remn, move_len;
  logic        zero1, remnz1;
  logic [56:0] acc_prod, dec_prod;
  logic [55:0] da;
  logic [31:0] vv;
  logic [39:0] av;
  logic [33:0] at;
  logic        zero2, remnz2;
  logic [56:0] num;

  assign num = 57'(vv) + 57'(da);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= '0;
    end else begin
      if (take[0]) out_valid[0] <= in_valid;
      if (take[1]) out_valid[1] <= out_valid[0];
      if (take[2]) out_valid[2] <= out_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      trav     <= abs_diff(start_pos, cur);
      remn     <= abs_diff(cur, target_pos);
      move_len <= abs_diff(start_pos, target_pos);
      zero1    <= (start_pos == target_pos);
      remnz1   <= (cur != target_pos);
    end
    if (take[1]) begin
      acc_prod <= 57'(a_eff) * 57'({1'b0, trav} + 33'd1);
      dec_prod <= 57'(a_eff) * 57'({1'b0, remn} + 33'd1);
      da       <= 56'(move_len) * 56'(a_eff);
      vv       <= 32'(v_eff) * 32'(v_eff);
      av       <= 40'(a_eff) * 40'(v_eff);
      at       <= 34'(a_eff) * 34'(t_eff);
      zero2    <= zero1;
      remnz2   <= remnz1;
    end
    if (take[2]) begin
      // A ramp radicand of 2^31 or more cannot set the minimum.
      out_data.acc.rad       <= {acc_prod[30:0], 17'd0};
      out_data.acc.rem       <= '0;
      out_data.acc.root      <= '0;
      out_data.dec.rad       <= {dec_prod[30:0], 17'd0};
      out_data.dec.rem       <= '0;
      out_data.dec.root      <= '0;
      out_data.pk.rad        <= {da[31:0], 16'd0};
      out_data.pk.rem        <= '0;
      out_data.pk.root       <= '0;
      out_data.side.zero     <= zero2;
      out_data.side.remnz    <= remnz2;
      out_data.side.is_tri   <= (da < 56'(vv));
      out_data.side.acc_sat  <= (acc_prod[56:31] != '0);
      out_data.side.dec_sat  <= (dec_prod[56:31] != '0);
      out_data.side.tnum     <= 67'(num) * 67'(TICK_SCALE);
      out_data.side.avt      <= 50'(av) * 50'(t_eff);
      out_data.side.tden     <= {at, 8'd0};
    end
  end

endmodule

/* rtl/tsrp_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// tsrp_sqrt_cell: one digit step of three square roots
// Each cell retires two radicand bits per lane and passes the rest along.
// ---------------------------------------------------------------------------
module tsrp_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                in_valid,
  input  tsrp_pkg::sq_stage_t in_data,
  output logic                out_valid,
  output tsrp_pkg::sq_stage_t out_data
);
  import tsrp_pkg::*;

  function automatic sq_lane_t lane_step(input sq_lane_t l);
    sq_lane_t    o;
    logic [27:0] sh, trial;
    sh    = {l.rem, l.rad[47:46]};
    trial = {2'b00, l.root, 2'b01};
    o.rad = {l.rad[45:0], 2'b00};
    if (sh >= trial) begin
      o.rem  = 26'(sh - trial);
      o.root = {l.root[22:0], 1'b1};
    end else begin
      o.rem  = sh[25:0];
      o.root = {l.root[22:0], 1'b0};
    end
    lane_step = o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.acc  <= lane_step(in_data.acc);
      out_data.dec  <= lane_step(in_data.dec);
      out_data.pk   <= lane_step(in_data.pk);
      out_data.side <= in_data.side;
    end
  end

endmodule

/* rtl/tsrp_div_cell.sv */
// ---------------------------------------------------------------------------
// tsrp_div_cell: one restoring division step
// Brings in one dividend bit, subtracts the divisor when it fits and
// shifts one quotient bit in.
// ---------------------------------------------------------------------------
module tsrp_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                in_valid,
  input  tsrp_pkg::dv_stage_t in_data,
  output logic                out_valid,
  output tsrp_pkg::dv_stage_t out_data
);
  import tsrp_pkg::*;

  logic [50:0] trial, diff;
  logic        ge;
  dv_stage_t   out_next;

  assign trial = {in_data.r, in_data.n[32]};
  assign diff  = trial - {1'b0, in_data.d};
  assign ge    = (trial >= {1'b0, in_data.d});

  always_comb begin
    out_next   = in_data;
    out_next.n = {in_data.n[31:0], 1'b0};
    out_next.r = ge ? diff[49:0] : trial[49:0];
    out_next.q = {in_data.q[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= out_next;
    end
  end

endmodule

/* rtl/trapezoid_step_rate_planner.sv */
// Throughput: one position per cycle while rate_out.ready is high; each
// stage holds one item and moves on whenever the stage after it is empty or
// moving, so bubbles collapse.
// The chain is 3 product stages, 24 square root cells, a select stage,
// 33 divider cells and the output register.
// Reset clears every stage's valid bit and loads the register defaults.
// ---------------------------------------------------------------------------
// trapezoid_step_rate_planner: trapezoidal step rate planner, top level
// Holds the move registers and strings the cell chains together.
// ---------------------------------------------------------------------------
module trapezoid_step_rate_planner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsrp_pkg::CFG_DATA_W-1:0] cfg_data,
  tsrp_in_if.sink                         pos_in,
  tsrp_out_if.source                      rate_out
);
  import tsrp_pkg::*;

  localparam int QS = FRONT_STAGES + SQ_STEPS;
  localparam int OS = NST - 1;

  logic signed [31:0] start_position, target_position;
  logic [15:0] max_velocity, min_rate;
  logic [23:0] acceleration;
  logic [9:0]  tick_period_ms, tick_margin;
  logic [15:0] v_eff;
  logic [23:0] a_eff;
  logic [9:0]  t_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position  <= '0;
      target_position <= '0;
      max_velocity    <= MAX_VEL_RST;
      acceleration    <= ACCEL_RST;
      min_rate        <= MIN_RATE_RST;
      tick_period_ms  <= TICK_MS_RST;
      tick_margin     <= TICK_MARG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_POS:  start_position  <= cfg_data;
        REG_TARGET_POS: target_position <= cfg_data;
        REG_MAX_VEL:    max_velocity    <= cfg_data[15:0];
        REG_ACCEL:      acceleration    <= cfg_data[23:0];
        REG_MIN_RATE:   min_rate        <= cfg_data[15:0];
        REG_TICK_MS:    tick_period_ms  <= cfg_data[9:0];
        REG_TICK_MARG:  tick_margin     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // A zero limit behaves as one.
  assign v_eff = (max_velocity == '0) ? 16'd1 : max_velocity;
  assign a_eff = (acceleration == '0) ? 24'd1 : acceleration;
  assign t_eff = (tick_period_ms == '0) ? 10'd1 : tick_period_ms;

  logic [NST-1:0] vld;
  logic [NST:0]   take;
  logic           vld_sel, vld_out;

  assign take[NST] = rate_out.ready;
  for (genvar k = 0; k < NST; k++) begin : g_take
    assign take[k] = !vld[k] || take[k+1];
  end
  assign pos_in.ready = take[0];

  sq_stage_t sq_d [0:SQ_STEPS];
  dv_stage_t dv_d [0:DIV_STEPS];
  dv_stage_t dv_first;

  tsrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take[2:0]),
    .in_valid   (pos_in.valid),
    .cur        (pos_in.current_position),
    .start_pos  (start_position),
    .target_pos (target_position),
    .v_eff      (v_eff),
    .a_eff      (a_eff),
    .t_eff      (t_eff),
    .out_valid  (vld[2:0]),
    .out_data   (sq_d[0])
  );

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    tsrp_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .take      (take[FRONT_STAGES+j]),
      .in_valid  (vld[FRONT_STAGES-1+j]),
      .in_data   (sq_d[j]),
      .out_valid (vld[FRONT_STAGES+j]),
      .out_data  (sq_d[j+1])
    );
  end

  // Select stage: profile peak, rate minimum and divider setup.
  sq_stage_t   sq_last;
  logic [23:0] peak, r_acc, r_dec, rate_min, rate_sel, floor_q;
  logic [66:0] div_n;
  logic [49:0] div_d;
  dv_stage_t   dv_next;

  assign sq_last = sq_d[SQ_STEPS];

  always_comb begin
    peak     = sq_last.side.is_tri ? sq_last.pk.root : {v_eff, 8'd0};
    r_acc    = sq_last.side.acc_sat ? RATE_SAT : sq_last.acc.root;
    r_dec    = sq_last.side.dec_sat ? RATE_SAT : sq_last.dec.root;
    rate_min = peak;
    if (r_acc < rate_min) rate_min = r_acc;
    if (r_dec < rate_min) rate_min = r_dec;
    floor_q  = {min_rate, 8'd0};
    rate_sel = rate_min;
    if (sq_last.side.remnz && (rate_min < floor_q)) begin
      rate_sel = (peak < floor_q) ? peak : floor_q;
    end
    if (sq_last.side.is_tri) begin
      div_n = 67'(35'(peak) * 35'(TRI_SCALE));
      div_d = 50'(sq_last.side.tden);
    end else begin
      div_n = sq_last.side.tnum;
      div_d = sq_last.side.avt;
    end
    dv_next.n      = div_n[32:0];
    dv_next.r      = 50'(div_n[66:33]);
    dv_next.q      = '0;
    dv_next.d      = div_d;
    // A quotient of 2^33 or more saturates the estimate anyway.
    dv_next.ovf    = (50'(div_n[66:33]) >= div_d);
    dv_next.zero   = sq_last.side.zero;
    dv_next.is_tri = sq_last.side.is_tri;
    dv_next.rate   = rate_sel;
    dv_next.peak   = peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sel <= 1'b0;
    end else if (take[QS]) begin
      vld_sel <= vld[QS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (take[QS]) dv_first <= dv_next;
  end

  assign vld[QS] = vld_sel;
  assign dv_d[0] = dv_first;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tsrp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .take      (take[QS+1+j]),
      .in_valid  (vld[QS+j]),
      .in_data   (dv_d[j]),
      .out_valid (vld[QS+1+j]),
      .out_data  (dv_d[j+1])
    );
  end

  // Output register.
  dv_stage_t   dv_last;
  logic [33:0] est_sum;
  logic [23:0] step_rate, peak_velocity;
  logic        triangular;
  logic [31:0] tick_estimate;

  assign dv_last = dv_d[DIV_STEPS];
  assign est_sum = 34'(dv_last.q) + 34'(tick_margin);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (take[OS]) begin
      vld_out <= vld[OS-1];
    end
  end

  assign vld[OS] = vld_out;

  always_ff @(posedge clk) begin
    if (take[OS]) begin
      if (dv_last.zero) begin
        step_rate     <= '0;
        peak_velocity <= '0;
        triangular    <= 1'b1;
        tick_estimate <= '0;
      end else begin
        step_rate     <= dv_last.rate;
        peak_velocity <= dv_last.peak;
        triangular    <= dv_last.is_tri;
        if (dv_last.ovf || (est_sum[33:32] != 2'b00)) begin
          tick_estimate <= '1;
        end else begin
          tick_estimate <= est_sum[31:0];
        end
      end
    end
  end

  assign rate_out.valid         = vld[OS];
  assign rate_out.step_rate     = step_rate;
  assign rate_out.peak_velocity = peak_velocity;
  assign rate_out.triangular    = triangular;
  assign rate_out.tick_estimate = tick_estimate;

`ifndef SYNTHESIS
  // A zero peak only comes from a zero-length move.
  a_zero_move: assert property (@(posedge clk) disable iff (rst)
    rate_out.valid && (rate_out.peak_velocity == '0) |->
      (rate_out.step_rate == '0) && rate_out.triangular &&
      (rate_out.tick_estimate == '0))
    else $error("zero-length move gave a nonzero result");

  a_rate_le_peak: assert property (@(posedge clk) disable iff (rst)
    rate_out.valid |-> (rate_out.step_rate <= rate_out.peak_velocity))
    else $error("step rate above profile peak");

  a_cruise_peak: assert property (@(posedge clk) disable iff (rst)
    rate_out.valid && !rate_out.triangular |->
      (rate_out.peak_velocity == {v_eff, 8'd0}))
    else $error("trapezoidal peak differs from cruise velocity");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[OS] |-> pos_in.ready)
    else $error("input stalled while output stage is empty");
`endif

endmodule
